### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BR1D_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BR1D_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/br1d_pkg.sv
// ----------------------------------------------------------------------------
// ByteRun1 bitplane decoder package
// Types, register indexes and limits shared by the decoder modules.
// ----------------------------------------------------------------------------
package br1d_pkg;

	localparam int unsigned MAX_ROW_BYTES = 160;
	localparam int unsigned MAX_PLANES    = 8;
	localparam int unsigned MAX_LINES     = 4096;
	localparam int unsigned QUEUE_DEPTH   = 4;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 13;
	localparam int unsigned LINE_CMP_W = 17;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_COUNT     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MASK_ENABLE     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COMPRESSED_MODE = 3'd4;

	localparam logic [7:0] HDR_SKIP   = 8'h80;
	localparam logic [7:0] COUNT_MASK = 8'h7f;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_LITERAL,
		PH_VALUE,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic [7:0] body_byte;
		logic       image_start;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  pixel_value;
		logic [7:0]  run_length;
		logic [11:0] line_index;
		logic [3:0]  plane_index;
		logic [7:0]  start_column;
		logic        store_enable;
		logic        row_overrun;
		logic        image_done;
	} result_t;

	typedef struct packed {
		logic [7:0]  row_bytes;
		logic [3:0]  plane_count;
		logic        mask_enable;
		logic [12:0] line_count;
		logic        compressed_mode;
	} cfg_t;

	// One classified body byte. count is the literal length for a literal
	// header and the repeat count for a repeat header.
	typedef struct packed {
		logic [7:0] value;
		logic       restart;
		logic       lit_hdr;
		logic       skip;
		logic [7:0] count;
	} cmd_t;

endpackage

### rtl/core/byterun1_bitplane_decoder_top.sv
// ----------------------------------------------------------------------------
// ByteRun1 bitplane decoder
// Decodes a ByteRun1 picture body into runs tagged with line, plane and column.
// ----------------------------------------------------------------------------
// The decoder takes one body byte per clock and gives at most one run result
// per byte, so it sustains one byte per cycle while results are popped. A
// result reaches the result port by way of the command queue, which takes the
// byte when it is accepted, and the back end, which then registers its run in
// its result register. The back end updates its run and position counters
// once for each byte that it takes; full rises only when QUEUE_DEPTH bytes
// wait behind an unpopped result. Registers must be written only while the
// decoder is idle; the decoder itself does not enforce this.
module byterun1_bitplane_decoder_top #(
	parameter int unsigned QUEUE_DEPTH = br1d_pkg::QUEUE_DEPTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  br1d_pkg::in_item_t                 item,
	output logic                               empty,
	input  logic                               pop,
	output br1d_pkg::result_t                  result,
	input  logic                               cfg_we,
	input  logic [br1d_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [br1d_pkg::CFG_DATA_W-1:0]    cfg_data
);

	br1d_pkg::cfg_t cfg_q;
	br1d_pkg::cmd_t front_cmd;
	br1d_pkg::cmd_t queue_cmd;
	logic           front_wr;
	logic           queue_valid;
	logic           back_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row_bytes       <= 8'd40;
			cfg_q.plane_count     <= 4'd5;
			cfg_q.mask_enable     <= 1'b0;
			cfg_q.line_count      <= 13'd256;
			cfg_q.compressed_mode <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				br1d_pkg::REG_ROW_BYTES:       cfg_q.row_bytes       <= cfg_data[7:0];
				br1d_pkg::REG_PLANE_COUNT:     cfg_q.plane_count     <= cfg_data[3:0];
				br1d_pkg::REG_MASK_ENABLE:     cfg_q.mask_enable     <= cfg_data[0];
				br1d_pkg::REG_LINE_COUNT:      cfg_q.line_count      <= cfg_data[12:0];
				br1d_pkg::REG_COMPRESSED_MODE: cfg_q.compressed_mode <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	br1d_front u_front (
		.push   (push),
		.q_full (full),
		.item   (item),
		.wr     (front_wr),
		.cmd    (front_cmd)
	);

	br1d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (front_wr),
		.wr_data  (front_cmd),
		.full     (full),
		.rd       (back_take),
		.rd_valid (queue_valid),
		.rd_data  (queue_cmd)
	);

	br1d_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (queue_valid),
		.cmd       (queue_cmd),
		.take      (back_take),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

### rtl/core/br1d_front.sv
// ----------------------------------------------------------------------------
// ByteRun1 decoder front end
// Accepts body bytes and classifies each one as a possible run header.
// ----------------------------------------------------------------------------
module br1d_front (
	input  logic              push,
	input  logic              q_full,
	input  br1d_pkg::in_item_t item,
	output logic              wr,
	output br1d_pkg::cmd_t    cmd
);

	logic [8:0] rep_sum;

	assign wr      = push && !q_full;
	assign rep_sum = 9'd257 - {1'b0, item.body_byte};

	always_comb begin
		cmd.value   = item.body_byte;
		cmd.restart = item.image_start;
		cmd.lit_hdr = !item.body_byte[7];
		cmd.skip    = (item.body_byte == br1d_pkg::HDR_SKIP);
		if (!item.body_byte[7]) begin
			cmd.count = (item.body_byte & br1d_pkg::COUNT_MASK) + 8'd1;
		end else begin
			cmd.count = rep_sum[7:0];
		end
	end

endmodule

### rtl/core/br1d_queue.sv
// ----------------------------------------------------------------------------
// ByteRun1 decoder command queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module br1d_queue #(
	parameter int unsigned DEPTH = br1d_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  br1d_pkg::cmd_t wr_data,
	output logic           full,
	input  logic           rd,
	output logic           rd_valid,
	output br1d_pkg::cmd_t rd_data
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	br1d_pkg::cmd_t   entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == FULL_CNT);
	assign rd_valid = (count_q != '0);
	assign rd_data  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			entries_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/core/br1d_back.sv
// ----------------------------------------------------------------------------
// ByteRun1 decoder back end
// Runs the run-length state machine, tracks row position and holds results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module br1d_back (
	input  logic              clk,
	input  logic              arst_n,
	input  br1d_pkg::cfg_t    cfg,
	input  logic              cmd_valid,
	input  br1d_pkg::cmd_t    cmd,
	output logic              take,
	output logic              empty,
	input  logic              pop,
	output br1d_pkg::result_t result
);

	localparam logic [8:0] ROW_CAP = 9'(br1d_pkg::MAX_ROW_BYTES);
	localparam logic [4:0] PLANE_CAP = 5'(br1d_pkg::MAX_PLANES);
	localparam logic [br1d_pkg::LINE_CMP_W-1:0] LINE_CAP =
		br1d_pkg::LINE_CMP_W'(br1d_pkg::MAX_LINES);

	br1d_pkg::phase_t phase_q;
	logic [7:0]       lit_left_q;
	logic [7:0]       rep_q;
	logic [7:0]       col_q;
	logic [3:0]       plane_q;
	logic [11:0]      line_q;
	logic             out_valid_q;
	br1d_pkg::result_t out_q;

	logic [7:0] eff_rows;
	logic [3:0] eff_planes;
	logic [4:0] total_planes;
	logic [br1d_pkg::LINE_CMP_W-1:0] eff_lines;

	br1d_pkg::phase_t ph_c;
	br1d_pkg::phase_t ph_n;
	logic [7:0]  lit_c, rep_c, col_c;
	logic [3:0]  plane_c;
	logic [11:0] line_c;
	logic        ignore;

	logic        emit, run_end, ovr, finish;
	logic [7:0]  len;
	logic [8:0]  col_sum;
	logic [7:0]  col_adv;
	logic [7:0]  lit_n, rep_n, col_n;
	logic [3:0]  plane_n;
	logic [11:0] line_n;
	br1d_pkg::result_t res;

	assign take   = cmd_valid && (!out_valid_q || pop);
	assign empty  = !out_valid_q;
	assign result = out_q;

	always_comb begin
		eff_rows   = ({1'b0, cfg.row_bytes} > ROW_CAP) ? ROW_CAP[7:0] : cfg.row_bytes;
		eff_planes = ({1'b0, cfg.plane_count} > PLANE_CAP) ? PLANE_CAP[3:0] : cfg.plane_count;
		total_planes = {1'b0, eff_planes} + {4'd0, cfg.mask_enable};
		if (total_planes == 5'd0) begin
			total_planes = 5'd1;
		end
		eff_lines = (br1d_pkg::LINE_CMP_W'(cfg.line_count) > LINE_CAP) ? LINE_CAP :
			br1d_pkg::LINE_CMP_W'(cfg.line_count);
	end

	// Position as seen by this byte, after an optional picture restart.
	always_comb begin
		if (cmd.restart) begin
			ph_c    = br1d_pkg::PH_HEADER;
			lit_c   = '0;
			rep_c   = '0;
			col_c   = '0;
			plane_c = '0;
			line_c  = '0;
		end else begin
			ph_c    = phase_q;
			lit_c   = lit_left_q;
			rep_c   = rep_q;
			col_c   = col_q;
			plane_c = plane_q;
			line_c  = line_q;
		end
		ignore = (ph_c == br1d_pkg::PH_DONE) ||
			(br1d_pkg::LINE_CMP_W'(line_c) >= eff_lines);
	end

	// Run datapath and row-end bookkeeping.
	always_comb begin
		emit    = 1'b0;
		run_end = 1'b0;
		len     = 8'd1;
		lit_n   = lit_c;
		rep_n   = rep_c;
		if (!ignore) begin
			if (!cfg.compressed_mode) begin
				emit    = 1'b1;
				run_end = 1'b1;
			end else begin
				case (ph_c)
					br1d_pkg::PH_HEADER: begin
						if (cmd.lit_hdr) begin
							lit_n = cmd.count;
						end else if (!cmd.skip) begin
							rep_n = cmd.count;
						end
					end
					br1d_pkg::PH_LITERAL: begin
						emit    = 1'b1;
						lit_n   = (lit_c != 8'd0) ? lit_c - 8'd1 : 8'd0;
						run_end = (lit_n == 8'd0);
					end
					br1d_pkg::PH_VALUE: begin
						emit    = 1'b1;
						len     = rep_c;
						rep_n   = 8'd0;
						run_end = 1'b1;
					end
					default: begin
					end
				endcase
			end
		end

		col_sum = {1'b0, col_c} + {1'b0, len};
		col_adv = col_sum[8] ? 8'hff : col_sum[7:0];
		ovr     = (col_sum > {1'b0, eff_rows});
		col_n   = emit ? col_adv : col_c;

		plane_n = plane_c;
		line_n  = line_c;
		finish  = 1'b0;
		if (run_end && (col_adv >= eff_rows)) begin
			col_n = 8'd0;
			if (({1'b0, plane_c} + 5'd1) < total_planes) begin
				plane_n = plane_c + 4'd1;
			end else begin
				plane_n = 4'd0;
				if ((br1d_pkg::LINE_CMP_W'(line_c) + 1'b1) >= eff_lines) begin
					finish = 1'b1;
				end else begin
					line_n = line_c + 12'd1;
				end
			end
		end

		res.pixel_value  = cmd.value;
		res.run_length   = len;
		res.line_index   = line_c;
		res.plane_index  = plane_c;
		res.start_column = col_c;
		res.store_enable = (plane_c < eff_planes);
		res.row_overrun  = ovr;
		res.image_done   = finish;
	end

	// Next decoding phase.
	always_comb begin
		ph_n = ph_c;
		if (!ignore && cfg.compressed_mode) begin
			case (ph_c)
				br1d_pkg::PH_HEADER: begin
					if (cmd.lit_hdr) begin
						ph_n = br1d_pkg::PH_LITERAL;
					end else if (!cmd.skip) begin
						ph_n = br1d_pkg::PH_VALUE;
					end
				end
				br1d_pkg::PH_LITERAL: begin
					if (run_end) begin
						ph_n = br1d_pkg::PH_HEADER;
					end
				end
				br1d_pkg::PH_VALUE: begin
					ph_n = br1d_pkg::PH_HEADER;
				end
				default: begin
					ph_n = ph_c;
				end
			endcase
		end
		if (finish) begin
			ph_n = br1d_pkg::PH_DONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= br1d_pkg::PH_HEADER;
			lit_left_q  <= '0;
			rep_q       <= '0;
			col_q       <= '0;
			plane_q     <= '0;
			line_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				phase_q    <= ph_n;
				lit_left_q <= lit_n;
				rep_q      <= rep_n;
				col_q      <= col_n;
				plane_q    <= plane_n;
				line_q     <= line_n;
			end
			if (take && emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			out_q <= res;
		end
	end

	`BR1D_ASSERT_IMPLY(a_literal_left, phase_q == br1d_pkg::PH_LITERAL, lit_left_q != 8'd0,
		"literal phase with no literal bytes left")
	`BR1D_ASSERT_IMPLY(a_repeat_count, phase_q == br1d_pkg::PH_VALUE, rep_q >= 8'd2,
		"repeat phase with a repeat count below two")
	`BR1D_ASSERT_IMPLY(a_run_length, out_valid_q, out_q.run_length != 8'd0,
		"result holds a zero run length")
	`BR1D_ASSERT_NEXT(a_image_done, take && finish,
		phase_q == br1d_pkg::PH_DONE && out_valid_q && out_q.image_done,
		"finished picture did not reach the done phase with a marked result")

endmodule

### test/byterun1_bitplane_decoder_checker.sv
// ----------------------------------------------------------------------------
// ByteRun1 bitplane decoder checker
// Watches the request, result and register ports of the decoder, predicts
// every run from its own copy of the decoding position and registers, and
// compares each popped run field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module byterun1_bitplane_decoder_checker
	import br1d_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic                  full,
	input  in_item_t              item,
	input  logic                  empty,
	input  logic                  pop,
	input  result_t               result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int unsigned           mismatches,
	output int unsigned           outstanding
);

	logic [7:0]  row_bytes_q;
	logic [3:0]  plane_count_q;
	logic        mask_enable_q;
	logic [12:0] line_count_q;
	logic        compressed_q;

	phase_t      phase;
	int unsigned literal_left;
	int unsigned repeat_left;
	int unsigned column;
	int unsigned plane;
	int unsigned line;

	result_t     runs_due[$];

	// Returns 1 when the byte produces a run, and updates the decoding position.
	function automatic bit decode_body_byte(input in_item_t req, output result_t run);
		int unsigned rows;
		int unsigned planes;
		int unsigned lines;
		int unsigned total;
		int unsigned len;
		int unsigned next_col;
		bit          ovr;
		bit          closes;

		rows   = row_bytes_q > MAX_ROW_BYTES ? MAX_ROW_BYTES : row_bytes_q;
		planes = plane_count_q > MAX_PLANES ? MAX_PLANES : plane_count_q;
		lines  = line_count_q > MAX_LINES ? MAX_LINES : line_count_q;
		total  = planes + mask_enable_q;
		if (total == 0) begin
			total = 1;
		end
		run = '0;

		if (req.image_start) begin
			phase        = PH_HEADER;
			literal_left = 0;
			repeat_left  = 0;
			column       = 0;
			plane        = 0;
			line         = 0;
		end
		if (phase == PH_DONE || line >= lines) begin
			return 1'b0;
		end

		if (!compressed_q) begin
			len    = 1;
			ovr    = column >= rows;
			closes = 1'b1;
		end else begin
			case (phase)
				PH_HEADER: begin
					if (req.body_byte < HDR_SKIP) begin
						literal_left = req.body_byte + 1;
						phase        = PH_LITERAL;
					end else if (req.body_byte != HDR_SKIP) begin
						repeat_left = 257 - req.body_byte;
						phase       = PH_VALUE;
					end
					return 1'b0;
				end
				PH_LITERAL: begin
					len          = 1;
					ovr          = column >= rows;
					literal_left = literal_left > 0 ? literal_left - 1 : 0;
					closes       = literal_left == 0;
					if (closes) begin
						phase = PH_HEADER;
					end
				end
				default: begin
					len         = repeat_left;
					ovr         = column + repeat_left > rows;
					repeat_left = 0;
					phase       = PH_HEADER;
					closes      = 1'b1;
				end
			endcase
		end

		run.pixel_value  = req.body_byte;
		run.run_length   = len[7:0];
		run.line_index   = line[11:0];
		run.plane_index  = plane[3:0];
		run.start_column = column[7:0];
		run.store_enable = plane < planes;
		run.row_overrun  = ovr;

		next_col = column + len;
		column   = next_col > 255 ? 255 : next_col;

		// The row only ends once a run has completed.
		if (closes && column >= rows) begin
			column = 0;
			if (plane + 1 < total) begin
				plane = (plane + 1) & 4'hf;
			end else begin
				plane = 0;
				if (line + 1 >= lines) begin
					phase          = PH_DONE;
					run.image_done = 1'b1;
				end else begin
					line = (line + 1) & 12'hfff;
				end
			end
		end
		return 1'b1;
	endfunction

	task automatic compare_field(input string name, input logic [11:0] want,
			input logic [11:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t run;
		result_t due;

		if (!arst_n) begin
			row_bytes_q   = 8'd40;
			plane_count_q = 4'd5;
			mask_enable_q = 1'b0;
			line_count_q  = 13'd256;
			compressed_q  = 1'b1;
			phase         = PH_HEADER;
			literal_left  = 0;
			repeat_left   = 0;
			column        = 0;
			plane         = 0;
			line          = 0;
			runs_due.delete();
			mismatches    = 0;
			outstanding  <= 0;
		end else begin
			if (pop && !empty) begin
				if (runs_due.size() == 0) begin
					$error("run popped while no run was expected");
					mismatches++;
				end else begin
					due = runs_due.pop_front();
					compare_field("pixel_value", 12'(due.pixel_value),
						12'(result.pixel_value));
					compare_field("run_length", 12'(due.run_length),
						12'(result.run_length));
					compare_field("line_index", due.line_index, result.line_index);
					compare_field("plane_index", 12'(due.plane_index),
						12'(result.plane_index));
					compare_field("start_column", 12'(due.start_column),
						12'(result.start_column));
					compare_field("store_enable", 12'(due.store_enable),
						12'(result.store_enable));
					compare_field("row_overrun", 12'(due.row_overrun),
						12'(result.row_overrun));
					compare_field("image_done", 12'(due.image_done),
						12'(result.image_done));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_ROW_BYTES:       row_bytes_q   = cfg_data[7:0];
					REG_PLANE_COUNT:     plane_count_q = cfg_data[3:0];
					REG_MASK_ENABLE:     mask_enable_q = cfg_data[0];
					REG_LINE_COUNT:      line_count_q  = cfg_data[12:0];
					REG_COMPRESSED_MODE: compressed_q  = cfg_data[0];
					default: ;
				endcase
			end
			if (push && !full) begin
				if (decode_body_byte(item, run)) begin
					runs_due.push_back(run);
				end
			end
			outstanding <= runs_due.size();
		end
	end

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// ByteRun1 bitplane decoder testbench
// Feeds the decoder a short directed body stream and then phases of random,
// mostly well-formed ByteRun1 and raw bodies under a range of row sizes,
// plane counts, mask and line settings, with random gaps on both sides.
// Checking of every run is done by the checker instantiated beside the block.
// ----------------------------------------------------------------------------
module tb;
	import br1d_pkg::*;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  push;
	logic                  full;
	in_item_t              item;
	logic                  empty;
	logic                  pop;
	result_t               result;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int unsigned           mismatches;
	int unsigned           outstanding;

	// Stimulus bookkeeping, used only to shape the body stream.
	bit          calm;
	bit          fresh;
	bit          raw_mode;
	int unsigned row_eff;
	int unsigned total_rows;
	int unsigned rows_done;
	int unsigned col;
	int unsigned sent;

	byterun1_bitplane_decoder_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	byterun1_bitplane_decoder_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.item        (item),
		.empty       (empty),
		.pop         (pop),
		.result      (result),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int unsigned idle_cycles();
		int unsigned r;

		if (calm) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(4, 30);
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic st);
		int unsigned gap;

		gap = idle_cycles();
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		item <= '{body_byte: b, image_start: st};
		do @(posedge clk); while (full);
		sent++;
	endtask

	task automatic note_columns(input int unsigned n);
		col += n;
		if (col >= row_eff) begin
			col = 0;
			rows_done++;
			if (rows_done >= total_rows) begin
				fresh = 1'b1;
			end
		end
	endtask

	// One request group: a header and its data, a raw byte, or some noise.
	task automatic send_packet();
		int unsigned rem;
		int unsigned n;
		int unsigned roll;
		logic        st;

		st = fresh || ($urandom_range(0, 39) == 0);
		if (st) begin
			col       = 0;
			rows_done = 0;
			fresh     = 1'b0;
		end
		rem = col < row_eff ? row_eff - col : 1;
		if (rem > 128) begin
			rem = 128;
		end
		roll = $urandom_range(0, 99);
		if (raw_mode) begin
			send_byte(8'($urandom_range(0, 255)), st);
			note_columns(1);
		end else if (roll < 4) begin
			send_byte(HDR_SKIP, st);
		end else if (roll < 12) begin
			send_byte(8'($urandom_range(0, 255)), st | ($urandom_range(0, 3) == 0));
		end else begin
			n = roll < 20 ? $urandom_range(1, 128) : $urandom_range(1, rem);
			if (n > 1 && roll[0]) begin
				send_byte(8'(257 - n), st);
				send_byte(8'($urandom_range(0, 255)), 1'b0);
			end else begin
				send_byte(8'(n - 1), st);
				repeat (n) send_byte(8'($urandom_range(0, 255)), 1'b0);
			end
			note_columns(n);
		end
	endtask

	// Waits until the block is idle: every run popped and the queue drained.
	task automatic settle();
		push <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (QUEUE_DEPTH + 12) @(posedge clk);
	endtask

	task automatic configure(input int unsigned row, input int unsigned planes,
			input bit mask, input int unsigned lines, input bit comp, input bit restart);
		logic [CFG_IDX_W-1:0]  idx[6];
		logic [CFG_DATA_W-1:0] val[6];
		logic [CFG_DATA_W-1:0] keep[6];
		int unsigned           count;
		int unsigned           planes_eff;
		int unsigned           total;

		settle();
		idx[0] = REG_ROW_BYTES;       val[0] = CFG_DATA_W'(row);    keep[0] = 13'h00ff;
		idx[1] = REG_PLANE_COUNT;     val[1] = CFG_DATA_W'(planes); keep[1] = 13'h000f;
		idx[2] = REG_MASK_ENABLE;     val[2] = CFG_DATA_W'(mask);   keep[2] = 13'h0001;
		idx[3] = REG_LINE_COUNT;      val[3] = CFG_DATA_W'(lines);  keep[3] = 13'h1fff;
		idx[4] = REG_COMPRESSED_MODE; val[4] = CFG_DATA_W'(comp);   keep[4] = 13'h0001;
		count = 5;
		// Unused register indexes must be ignored.
		if ($urandom_range(0, 3) == 0) begin
			idx[5]  = CFG_IDX_W'($urandom_range(5, 7));
			val[5]  = CFG_DATA_W'($urandom);
			keep[5] = 13'h1fff;
			count   = 6;
		end
		for (int i = 0; i < count; i++) begin
			// Bits above a register's width are sometimes set and must be dropped.
			if ($urandom_range(0, 4) == 0) begin
				val[i] = val[i] | (CFG_DATA_W'($urandom) & ~keep[i]);
			end
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;

		row_eff    = row > MAX_ROW_BYTES ? MAX_ROW_BYTES : row;
		planes_eff = planes > MAX_PLANES ? MAX_PLANES : planes;
		total      = planes_eff + mask;
		if (total == 0) begin
			total = 1;
		end
		total_rows = total * (lines > MAX_LINES ? MAX_LINES : lines);
		raw_mode   = !comp;
		calm       = $urandom_range(0, 3) == 0;
		if (restart) begin
			fresh = 1'b1;
		end
	endtask

	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		pop = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			int unsigned gap;

			gap = idle_cycles();
			if (gap != 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
		end
	end

	initial begin
		logic [7:0]  directed[$];
		int unsigned quota;
		int unsigned first;

		arst_n    = 1'b0;
		push      = 1'b0;
		item      = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		calm      = 1'b0;
		fresh     = 1'b1;
		col       = 0;
		rows_done = 0;
		sent      = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Literal of one, skip header, overrunning repeat of 128, repeat of two,
		// literals ending rows, the mask plane, and bytes after the image is done.
		configure(4, 1, 1'b1, 2, 1'b1, 1'b1);
		directed = '{8'h00, 8'hff, 8'h80, 8'h81, 8'h00, 8'hff, 8'ha5, 8'h01, 8'h12,
			8'h34, 8'hfe, 8'h5a, 8'h00, 8'h77, 8'h03, 8'h01, 8'h02, 8'h04, 8'h08,
			8'h7f, 8'h10, 8'h20};
		foreach (directed[i]) begin
			send_byte(directed[i], i == 0);
		end
		fresh = 1'b1;

		for (int p = 0; p < 12; p++) begin
			case (p)
				0: configure(0, 0, 1'b0, 3, 1'b1, 1'b1);
				1: configure(255, 15, 1'b1, 8191, 1'b1, 1'b1);
				2: configure(160, 8, 1'b0, 4096, 1'b0, 1'b0);
				3: configure(2, 1, 1'b0, 1, 1'b1, 1'b1);
				4: configure(5, 2, 1'b1, 0, 1'b1, 1'b1);
				5: configure(3, 8, 1'b1, 2, 1'b0, 1'b0);
				default: configure(
					$urandom_range(0, 4) != 0 ? $urandom_range(2, 8) : $urandom_range(0, 255),
					$urandom_range(0, 4) != 0 ? $urandom_range(0, 4) : $urandom_range(0, 15),
					1'($urandom_range(0, 1)),
					$urandom_range(0, 4) != 0 ? $urandom_range(1, 4) : $urandom_range(1, 8191),
					$urandom_range(0, 4) != 0,
					$urandom_range(0, 9) < 7);
			endcase
			quota = p == 4 ? 8 : 110;
			first = sent;
			while (sent - first < quota) begin
				send_packet();
			end
		end

		settle();
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

### byterun1_bitplane_decoder_top.f
+incdir+rtl/core
rtl/core/br1d_pkg.sv
rtl/core/br1d_front.sv
rtl/core/br1d_queue.sv
rtl/core/br1d_back.sv
rtl/core/byterun1_bitplane_decoder_top.sv
test/byterun1_bitplane_decoder_checker.sv
test/tb.sv
